/* rtl/bcrl_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bernoulli CUSUM run-length package
// Field widths, default parameter values, register map and reset values of
// the control registers.
// ----------------------------------------------------------------------------
package bcrl_pkg;

   // default parameter values
   localparam int SAMPLE_BITS_DEF = 16;
   localparam int SCORE_BITS_DEF  = 32;
   localparam int COUNT_BITS_DEF  = 32;

   // fixed field widths of the ports
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int THRESH_W    = 31;
   localparam int STEP_W      = 32;
   localparam int LEVEL_W     = 31;
   localparam int CUT_W       = 17;
   localparam int SCORE_OUT_W = 31;
   localparam int COUNT_OUT_W = 32;

   // register map
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_THRESHOLD    = 3'd0,
      CSR_STEP_IF_ONE  = 3'd1,
      CSR_STEP_IF_ZERO = 3'd2,
      CSR_RESET_LEVEL  = 3'd3,
      CSR_CUT_POINT    = 3'd4
   } csr_index_type;

   // register reset values
   localparam logic [THRESH_W-1:0] THRESHOLD_RST   = 31'd65536;
   localparam logic [STEP_W-1:0]   STEP_RST        = 32'd0;
   localparam logic [LEVEL_W-1:0]  RESET_LEVEL_RST = 31'd0;
   localparam logic [CUT_W-1:0]    CUT_POINT_RST   = 17'd32768;

endpackage

/* rtl/bernoulli_cusum_run_length.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bernoulli CUSUM run-length detector
// Adds one of two signed deflections per sample word to a score clamped at
// zero, raises an alarm at the threshold, reloads the head start and keeps
// alarm count and shortest / longest run lengths for each run.
// ----------------------------------------------------------------------------
// The response word for an accepted request word is registered and is valid in the cycle after it is accepted.
// Throughput: 1 word per cycle while the response side takes each word; the score add, clamp and threshold compare
//   are combinational between the state registers and the response register.
// Reset: synchronous, active high; control registers return to their default values,
//   score loads the default head start, run counters clear, shortest run sets to all ones. No clearing pass.
// ----------------------------------------------------------------------------
module bernoulli_cusum_run_length #(
   parameter int SAMPLE_BITS = bcrl_pkg::SAMPLE_BITS_DEF,
   parameter int SCORE_BITS  = bcrl_pkg::SCORE_BITS_DEF,
   parameter int COUNT_BITS  = bcrl_pkg::COUNT_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // request channel
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic [SAMPLE_BITS-1:0]              req_sample_value,
   input  logic                                req_end_of_run,
   // response channel
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic                                rsp_alarm,
   output logic [bcrl_pkg::SCORE_OUT_W-1:0]    rsp_score_out,
   output logic [bcrl_pkg::COUNT_OUT_W-1:0]    rsp_alarm_count,
   output logic [bcrl_pkg::COUNT_OUT_W-1:0]    rsp_last_alarm_index,
   output logic [bcrl_pkg::COUNT_OUT_W-1:0]    rsp_min_run,
   output logic [bcrl_pkg::COUNT_OUT_W-1:0]    rsp_max_run,
   output logic                                rsp_final_report,
   // control register write port
   input  logic                                csr_wr_en,
   input  logic [bcrl_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bcrl_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import bcrl_pkg::*;

   // score holds the head start even when SCORE_BITS is narrow
   localparam int SCORE_W = (SCORE_BITS > LEVEL_W) ? SCORE_BITS : LEVEL_W;
   localparam int SUM_W   = ((SCORE_W > STEP_W) ? SCORE_W : STEP_W) + 2;
   localparam int CMP_W   = (SAMPLE_BITS > CUT_W) ? SAMPLE_BITS : CUT_W;
   localparam int CEXT_W  = (COUNT_BITS > COUNT_OUT_W) ? COUNT_BITS : COUNT_OUT_W;
   localparam logic [SUM_W-1:0] SCORE_MAX = SUM_W'((65'd1 << SCORE_BITS) - 65'd1);

   // control registers
   logic [THRESH_W-1:0]   threshold_ff;
   logic [STEP_W-1:0]     step_one_ff;
   logic [STEP_W-1:0]     step_zero_ff;
   logic [LEVEL_W-1:0]    reset_level_ff;
   logic [CUT_W-1:0]      cut_point_ff;

   // run state
   logic [SCORE_W-1:0]    score_ff,        score_in;
   logic [COUNT_BITS-1:0] item_index_ff,   item_index_in;
   logic [COUNT_BITS-1:0] run_len_ff,      run_len_in;
   logic [COUNT_BITS-1:0] alarm_total_ff,  alarm_total_in;
   logic [COUNT_BITS-1:0] last_alarm_ff,   last_alarm_in;
   logic [COUNT_BITS-1:0] shortest_ff,     shortest_in;
   logic [COUNT_BITS-1:0] longest_ff,      longest_in;

   // response register
   logic                   rsp_valid_ff;
   logic                   alarm_ff,       alarm_in;
   logic [SCORE_OUT_W-1:0] score_out_ff;
   logic [COUNT_OUT_W-1:0] count_out_ff,   last_out_ff,  min_out_ff,  max_out_ff;
   logic [COUNT_OUT_W-1:0] count_out_in,   last_out_in,  min_out_in,  max_out_in;
   logic                   final_ff;

   logic                   req_accept;
   logic                   is_one;
   logic [STEP_W-1:0]      step_sel;
   logic signed [SUM_W-1:0] sum;
   logic                   idx_inc;
   logic [COUNT_BITS-1:0]  run_new;
   logic [CEXT_W-1:0]      count_ext, last_ext, min_ext, max_ext;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   // write control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff   <= THRESHOLD_RST;
         step_one_ff    <= STEP_RST;
         step_zero_ff   <= STEP_RST;
         reset_level_ff <= RESET_LEVEL_RST;
         cut_point_ff   <= CUT_POINT_RST;
      end else if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_THRESHOLD:    threshold_ff   <= csr_wr_data[THRESH_W-1:0];
            CSR_STEP_IF_ONE:  step_one_ff    <= csr_wr_data[STEP_W-1:0];
            CSR_STEP_IF_ZERO: step_zero_ff   <= csr_wr_data[STEP_W-1:0];
            CSR_RESET_LEVEL:  reset_level_ff <= csr_wr_data[LEVEL_W-1:0];
            CSR_CUT_POINT:    cut_point_ff   <= csr_wr_data[CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // pick the deflection and add it to the score
   always_comb begin
      is_one   = CMP_W'(req_sample_value) < CMP_W'(cut_point_ff);
      step_sel = is_one ? step_one_ff : step_zero_ff;
      sum      = $signed(SUM_W'(score_ff)) + $signed({{(SUM_W-STEP_W){step_sel[STEP_W-1]}},
                                                     step_sel});
   end

   // next run state
   always_comb begin
      idx_inc        = ~&item_index_ff;
      item_index_in  = item_index_ff + COUNT_BITS'(idx_inc);
      run_new        = run_len_ff + COUNT_BITS'(idx_inc);
      run_len_in     = run_new;
      alarm_total_in = alarm_total_ff;
      last_alarm_in  = last_alarm_ff;
      shortest_in    = shortest_ff;
      longest_in     = longest_ff;
      alarm_in       = 1'b0;
      if (sum < 0) begin
         score_in = '0;
      end else if (sum >= $signed(SUM_W'(threshold_ff))) begin
         alarm_in       = 1'b1;
         alarm_total_in = alarm_total_ff + COUNT_BITS'(~&alarm_total_ff);
         if (run_new > longest_ff) begin
            longest_in = run_new;
         end
         if (run_new < shortest_ff) begin
            shortest_in = run_new;
         end
         last_alarm_in = item_index_in;
         run_len_in    = '0;
         score_in      = SCORE_W'(reset_level_ff);
      end else if (sum > $signed(SCORE_MAX)) begin
         score_in = SCORE_W'(SCORE_MAX);
      end else begin
         score_in = SCORE_W'(sum);
      end
   end

   // format the response fields
   always_comb begin
      count_ext    = CEXT_W'(alarm_total_in);
      last_ext     = CEXT_W'(last_alarm_in);
      min_ext      = CEXT_W'(shortest_in);
      max_ext      = CEXT_W'(longest_in);
      count_out_in = count_ext[COUNT_OUT_W-1:0];
      last_out_in  = last_ext[COUNT_OUT_W-1:0];
      max_out_in   = max_ext[COUNT_OUT_W-1:0];
      if (req_end_of_run && (alarm_total_in == '0)) begin
         min_out_in = '0;
      end else begin
         min_out_in = min_ext[COUNT_OUT_W-1:0];
      end
   end

   // advance run state; clear it after the last word of a run
   always_ff @(posedge clock) begin
      if (reset) begin
         score_ff       <= SCORE_W'(RESET_LEVEL_RST);
         item_index_ff  <= '0;
         run_len_ff     <= '0;
         alarm_total_ff <= '0;
         last_alarm_ff  <= '0;
         shortest_ff    <= '1;
         longest_ff     <= '0;
      end else if (req_accept) begin
         if (req_end_of_run) begin
            score_ff       <= SCORE_W'(reset_level_ff);
            item_index_ff  <= '0;
            run_len_ff     <= '0;
            alarm_total_ff <= '0;
            last_alarm_ff  <= '0;
            shortest_ff    <= '1;
            longest_ff     <= '0;
         end else begin
            score_ff       <= score_in;
            item_index_ff  <= item_index_in;
            run_len_ff     <= run_len_in;
            alarm_total_ff <= alarm_total_in;
            last_alarm_ff  <= last_alarm_in;
            shortest_ff    <= shortest_in;
            longest_ff     <= longest_in;
         end
      end
   end

   // response valid: set on accept, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // hold the response word until taken
   always_ff @(posedge clock) begin
      if (req_accept) begin
         alarm_ff     <= alarm_in;
         score_out_ff <= score_in[SCORE_OUT_W-1:0];
         count_out_ff <= count_out_in;
         last_out_ff  <= last_out_in;
         min_out_ff   <= min_out_in;
         max_out_ff   <= max_out_in;
         final_ff     <= req_end_of_run;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_alarm            = alarm_ff;
   assign rsp_score_out        = score_out_ff;
   assign rsp_alarm_count      = count_out_ff;
   assign rsp_last_alarm_index = last_out_ff;
   assign rsp_min_run          = min_out_ff;
   assign rsp_max_run          = max_out_ff;
   assign rsp_final_report     = final_ff;

   // an accepted word always shows up on the response side
   a_accept_to_rsp: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_valid_ff)
      else $error("accepted word produced no response");

   // an alarm is always counted
   a_alarm_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && alarm_ff |-> count_out_ff != '0)
      else $error("alarm without alarm count");

   // once an alarm is seen, shortest run never exceeds longest run
   a_min_le_max: assert property (@(posedge clock) disable iff (reset)
      alarm_total_ff != '0 |-> shortest_ff <= longest_ff)
      else $error("shortest run above longest run");

   // the last word of a run leaves cleared counters behind
   a_run_cleared: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_end_of_run |=> item_index_ff == '0 && alarm_total_ff == '0
                                       && run_len_ff == '0)
      else $error("counters not cleared after end of run");

endmodule
